### rtl/bitmap_first_fit_allocator_assert.svh
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator_assert.svh
// assertion macros used by the allocator rtl
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BFFA_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("allocator check failed");

// next-cycle implication, checked out of reset
`define BFFA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("allocator sequencing check failed");

`endif

### rtl/bffa_pkg.sv
// ----------------------------------------------------------------------------
// bffa_pkg
// shared constants and types of the bitmap first-fit allocator
// ----------------------------------------------------------------------------
package bffa_pkg;

    // width of a chunk index on the ports
    localparam int INDEX_W = 17;

    // request codes
    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_MARK  = 1'b1
    } op_t;

endpackage

### rtl/bffa_divider.sv
// ----------------------------------------------------------------------------
// bffa_divider
// two-stage constant divider: chunk index into map word and bit position
// ----------------------------------------------------------------------------
module bffa_divider
    import bffa_pkg::*;
#(
    parameter int DIVISOR = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [INDEX_W-1:0]         dividend,
    output logic                       done,
    output logic [INDEX_W-1:0]         quotient,
    output logic [$clog2(DIVISOR)-1:0] remainder
);

    localparam int REM_W   = $clog2(DIVISOR);
    localparam int SHIFT   = INDEX_W + REM_W;
    localparam int RECIP_W = INDEX_W + 2;
    localparam int PROD_W  = INDEX_W + RECIP_W;
    // ceil(2^SHIFT / DIVISOR), exact for every index value
    localparam longint RECIP = ((longint'(1) << SHIFT) + DIVISOR - 1) / DIVISOR;

    logic [PROD_W-1:0]  product;
    logic [INDEX_W-1:0] back;
    logic               step_reg;
    logic               done_reg;
    logic [INDEX_W-1:0] num_reg;
    logic [INDEX_W-1:0] quot_reg;
    logic [REM_W-1:0]   rem_reg;

    // stage 1: quotient by reciprocal multiply, stage 2: remainder
    assign product = PROD_W'(dividend) * PROD_W'(RECIP);
    assign back    = quot_reg * INDEX_W'(DIVISOR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= start;
            done_reg <= step_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg  <= dividend;
            quot_reg <= INDEX_W'(product >> SHIFT);
        end
        if (step_reg) begin
            rem_reg <= REM_W'(num_reg - back);
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

### rtl/bitmap_first_fit_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator
// one-bit-per-chunk allocation map with lowest-free allocate and mark
// ----------------------------------------------------------------------------
// The map lives in a single-port-write, registered-read memory of
// ceil(min(MAP_BITS, 2^17) / WORD_BITS) words (4096 words at the defaults).
// After reset the block sweeps that memory to zero, one word a cycle, and
// accepts no word on the input channel until the sweep is done. An allocate
// word reads the map starting at a scan hint, the lowest map word that may
// still hold a free chunk; for each map word visited it reads, then examines
// and writes back, and besides that it accepts the word and hands the result
// to the output register. The hint only moves up, since bits are never
// cleared, so over a run the scan cost is spread across all allocations. A
// mark word splits the chunk index into word and bit with a two-stage
// reciprocal multiply and then does one read-modify-write. An out-of-range
// mark, or an allocate once the map is known to be full, goes straight from
// accept to handing its result to the output register. One word is in
// flight at a time; a finished result sits in the output register and the
// next input word may be accepted while it waits.
// ----------------------------------------------------------------------------
`include "bitmap_first_fit_allocator_assert.svh"

module bitmap_first_fit_allocator
    import bffa_pkg::*;
#(
    parameter int MAP_BITS  = 131072,
    parameter int WORD_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic [INDEX_W-1:0] s_chunk_index,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [INDEX_W-1:0] m_result_index,
    output logic               m_found
);

    // chunks beyond the index field can never be named, so they are left out
    localparam int LIMIT      = (MAP_BITS < (1 << INDEX_W)) ? MAP_BITS : (1 << INDEX_W);
    localparam int SCAN_WORDS = (LIMIT + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W     = (SCAN_WORDS > 1) ? $clog2(SCAN_WORDS) : 1;
    localparam int HINT_W     = $clog2(SCAN_WORDS + 1);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int LAST_VALID = LIMIT - (SCAN_WORDS - 1) * WORD_BITS;
    // valid chunk bits of the last map word
    localparam logic [WORD_BITS-1:0] LAST_MASK =
        {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_VALID);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SCAN_WORDS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_EXAM,
        ST_DELIVER
    } state_t;

    state_t             state_reg;
    op_t                op_reg;
    logic [INDEX_W-1:0] chunk_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [BIT_W-1:0]   bit_reg;
    logic [HINT_W-1:0]  hint_reg;
    logic [INDEX_W-1:0] res_index_reg;
    logic               res_found_reg;
    logic               m_valid_reg;
    logic [INDEX_W-1:0] m_result_index_reg;
    logic               m_found_reg;

    // map memory
    logic [WORD_BITS-1:0] map_mem [SCAN_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_en;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;

    // divider hookup
    logic               div_start;
    logic               div_done;
    logic [INDEX_W-1:0] div_quot;
    logic [BIT_W-1:0]   div_rem;

    // examine-stage logic
    logic [WORD_BITS-1:0] masked_word;
    logic                 word_full;
    logic [WORD_BITS-1:0] free_onehot;
    logic [BIT_W-1:0]     free_bit;
    logic [WORD_BITS-1:0] mark_onehot;
    logic [INDEX_W-1:0]   alloc_index;
    logic                 accept;

    // checker terms
    logic                 write_state_ok;
    logic                 exam_alloc_hit;
    logic                 exam_write;

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    // the divider takes the index straight off the port at the accept edge
    bffa_divider #(
        .DIVISOR (WORD_BITS)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (s_chunk_index),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // the last word's unreachable bits count as used
    assign masked_word = rd_data_reg | ((addr_reg == LAST_ADDR) ? ~LAST_MASK : '0);
    assign word_full   = &masked_word;
    // isolate the lowest zero bit
    assign free_onehot = ~masked_word & (masked_word + 1'b1);
    assign mark_onehot = WORD_BITS'(1) << bit_reg;

    always_comb begin
        free_bit = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (free_onehot[b]) begin
                free_bit = free_bit | BIT_W'(b);
            end
        end
    end

    assign alloc_index = INDEX_W'(addr_reg) * INDEX_W'(WORD_BITS) + INDEX_W'(free_bit);

    // memory port control
    always_comb begin
        rd_en   = (state_reg == ST_READ);
        wr_en   = 1'b0;
        wr_data = '0;
        case (state_reg)
            ST_CLEAR: begin
                wr_en = 1'b1;
            end
            ST_EXAM: begin
                if (op_reg == OP_MARK) begin
                    wr_en   = 1'b1;
                    wr_data = rd_data_reg | mark_onehot;
                end else if (!word_full) begin
                    wr_en   = 1'b1;
                    wr_data = rd_data_reg | free_onehot;
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // read-modify-write: the write lands before any later read of the map
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= map_mem[addr_reg];
        end
        if (wr_en) begin
            map_mem[addr_reg] <= wr_data;
        end
    end

    assign div_start = accept && (s_operation == OP_MARK) && (32'(s_chunk_index) < LIMIT);

    // sequencer and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            addr_reg    <= '0;
            hint_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // drained with nothing to reload behind it
            if (m_valid_reg && m_ready && (state_reg != ST_DELIVER)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    if (addr_reg == LAST_ADDR) begin
                        addr_reg  <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        op_reg    <= op_t'(s_operation);
                        chunk_reg <= s_chunk_index;
                        if (s_operation == OP_MARK) begin
                            if (32'(s_chunk_index) < LIMIT) begin
                                state_reg <= ST_DIV;
                            end else begin
                                // out of range mark: echo index, not found
                                res_index_reg <= s_chunk_index;
                                res_found_reg <= 1'b0;
                                state_reg     <= ST_DELIVER;
                            end
                        end else if (hint_reg == HINT_W'(SCAN_WORDS)) begin
                            // map already known full
                            res_index_reg <= '0;
                            res_found_reg <= 1'b0;
                            state_reg     <= ST_DELIVER;
                        end else begin
                            addr_reg  <= hint_reg[ADDR_W-1:0];
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        addr_reg  <= div_quot[ADDR_W-1:0];
                        bit_reg   <= div_rem;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_EXAM;
                end
                ST_EXAM: begin
                    if (op_reg == OP_MARK) begin
                        res_index_reg <= chunk_reg;
                        res_found_reg <= 1'b1;
                        state_reg     <= ST_DELIVER;
                    end else if (!word_full) begin
                        res_index_reg <= alloc_index;
                        res_found_reg <= 1'b1;
                        hint_reg      <= HINT_W'(addr_reg);
                        state_reg     <= ST_DELIVER;
                    end else if (addr_reg == LAST_ADDR) begin
                        // scanned to the end: map full
                        res_index_reg <= '0;
                        res_found_reg <= 1'b0;
                        hint_reg      <= HINT_W'(SCAN_WORDS);
                        state_reg     <= ST_DELIVER;
                    end else begin
                        addr_reg  <= addr_reg + 1'b1;
                        hint_reg  <= HINT_W'(addr_reg) + 1'b1;
                        state_reg <= ST_READ;
                    end
                end
                ST_DELIVER: begin
                    // output register free or being drained this cycle
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg        <= 1'b1;
                        m_result_index_reg <= res_index_reg;
                        m_found_reg        <= res_found_reg;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_index = m_result_index_reg;
    assign m_found        = m_found_reg;

    assign write_state_ok = (state_reg == ST_CLEAR) || (state_reg == ST_EXAM);
    assign exam_alloc_hit = (state_reg == ST_EXAM) && (op_reg == OP_ALLOC) && !word_full;
    assign exam_write     = (state_reg == ST_EXAM) && wr_en;

    // map writes happen only in the sweep or in the examine step
    `BFFA_ASSERT_NOW(a_write_state, aclk, aresetn, wr_en, write_state_ok)
    // a successful allocate never hands out a chunk past the limit
    `BFFA_ASSERT_NOW(a_alloc_range, aclk, aresetn, exam_alloc_hit, 32'(alloc_index) < LIMIT)
    // every write-back is followed by delivery of that result
    `BFFA_ASSERT_NEXT(a_exam_deliver, aclk, aresetn, exam_write, state_reg == ST_DELIVER)
    // the divider only finishes while a mark waits for it
    `BFFA_ASSERT_NOW(a_div_owner, aclk, aresetn, div_done, state_reg == ST_DIV)

endmodule

### test/tb_bitmap_first_fit_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_first_fit_allocator
// self-checking bench for the bitmap first-fit chunk allocator
// ----------------------------------------------------------------------------
// A queue-fed driver offers allocate and mark words on the request channel.
// A clocked monitor keeps its own copy of the allocation map, predicts each
// result as its request is taken, and checks results in order, field by
// field. The run covers a directed opening, four random phases with
// different amounts of idling, and one long receiver hold-off. It ends with
// a short directed tail of allocates and marks at the ends of the range.
// ----------------------------------------------------------------------------
module tb_bitmap_first_fit_allocator;
    import bffa_pkg::*;

    localparam int CHUNK_LIMIT = 131072;          // chunks that can be named
    localparam int WORD_W      = 32;
    localparam int MAP_WORDS   = CHUNK_LIMIT / WORD_W;
    localparam int HOLD_CYCLES = 400;             // long receiver hold-off

    typedef struct packed {
        op_t                op;
        logic [INDEX_W-1:0] idx;
    } chunk_req_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               found;
    } chunk_result_t;

    // dut ports, all inputs known from time zero
    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic               s_operation    = 1'b0;
    logic [INDEX_W-1:0] s_chunk_index  = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [INDEX_W-1:0] m_result_index;
    logic               m_found;

    // stimulus and prediction state
    chunk_req_t    pending_reqs[$];
    chunk_result_t expected_results[$];
    logic [WORD_W-1:0] chunk_words[MAP_WORDS];    // bench copy of the map
    int unsigned   low_word      = 0;             // no free chunk below this word
    int unsigned   used_count    = 0;
    int unsigned   error_count   = 0;
    int unsigned   taken_count   = 0;
    int unsigned   checked_count = 0;
    int unsigned   full_count    = 0;             // allocates that met a full map
    int unsigned   remark_count  = 0;             // marks of chunks already used

    // idling knobs, percent of cycles
    int unsigned   send_idle_pct  = 0;
    int unsigned   recv_stall_pct = 0;

    // long hold-off of the result channel
    logic          hold_go   = 1'b0;
    int unsigned   hold_left = HOLD_CYCLES;
    logic          hold_active;
    logic          req_taken = 1'b0;

    bitmap_first_fit_allocator u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_chunk_index  (s_chunk_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_index (m_result_index),
        .m_found        (m_found)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // set one chunk in the bench map, keeping the used count
    task automatic claim_chunk(input int unsigned c);
        if (!chunk_words[c / WORD_W][c % WORD_W]) begin
            chunk_words[c / WORD_W][c % WORD_W] = 1'b1;
            used_count++;
        end
    endtask

    // first-fit prediction for one accepted request word
    task automatic predict_chunk_result(input op_t op, input logic [INDEX_W-1:0] idx);
        chunk_result_t res;
        int unsigned   b;
        res.index = idx;
        res.found = 1'b0;
        if (op == OP_ALLOC) begin
            res.index = '0;
            // bits are never cleared, so the lowest free word only moves up
            while (low_word < MAP_WORDS && (&chunk_words[low_word]))
                low_word++;
            if (low_word < MAP_WORDS) begin
                b = 0;
                while (chunk_words[low_word][b])
                    b++;
                claim_chunk(low_word * WORD_W + b);
                res.index = INDEX_W'(low_word * WORD_W + b);
                res.found = 1'b1;
            end else begin
                full_count++;
            end
        end else begin
            if (idx < CHUNK_LIMIT) begin
                if (chunk_words[idx / WORD_W][idx % WORD_W])
                    remark_count++;
                claim_chunk(idx);
                res.found = 1'b1;
            end
        end
        expected_results.push_back(res);
    endtask

    task automatic queue_req(input op_t op, input int unsigned idx);
        chunk_req_t r;
        r.op  = op;
        r.idx = INDEX_W'(idx);
        pending_reqs.push_back(r);
    endtask

    // random mix; marks lean toward the low region where allocates land
    task automatic queue_random_reqs(input int unsigned n);
        int unsigned pick;
        for (int unsigned i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // chunk index is ignored for allocate, keep it noisy
                queue_req(OP_ALLOC, $urandom_range(0, CHUNK_LIMIT - 1));
            end else if (pick < 75) begin
                queue_req(OP_MARK, $urandom_range(0, 1023));
            end else if (pick < 92) begin
                queue_req(OP_MARK, $urandom_range(0, CHUNK_LIMIT - 1));
            end else begin
                // word boundaries and the top of the index range
                case ($urandom_range(0, 2))
                    0: queue_req(OP_MARK, CHUNK_LIMIT - 1);
                    1: queue_req(OP_MARK, $urandom_range(0, MAP_WORDS - 1) * WORD_W);
                    default: queue_req(OP_MARK, $urandom_range(1, MAP_WORDS) * WORD_W - 1);
                endcase
            end
        end
    endtask

    // block until every queued word went in and every result came back
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // receiver hold-off, counted here so it runs beside the sender
    always @(posedge aclk) begin
        if (hold_go && hold_left != 0)
            hold_left <= hold_left - 1;
    end
    assign hold_active = hold_go && (hold_left != 0);

    // request driver: new word at the falling edge once the last one was taken
    always @(negedge aclk) begin
        chunk_req_t r;
        if (aresetn && (!s_valid || req_taken)) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                r = pending_reqs.pop_front();
                s_valid       <= 1'b1;
                s_operation   <= r.op;
                s_chunk_index <= r.idx;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= aresetn && !hold_active && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor: check the result word first, then predict for the request word
    always @(posedge aclk) begin
        chunk_result_t exp;
        req_taken <= aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected: index %0d found %0b",
                       m_result_index, m_found);
                error_count++;
            end else begin
                exp = expected_results.pop_front();
                checked_count++;
                if (m_result_index !== exp.index) begin
                    $error("result_index mismatch: expected %0d actual %0d",
                           exp.index, m_result_index);
                    error_count++;
                end
                if (m_found !== exp.found) begin
                    $error("found mismatch: expected %0b actual %0b",
                           exp.found, m_found);
                    error_count++;
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            taken_count++;
            predict_chunk_result(op_t'(s_operation), s_chunk_index);
        end
    end

    // stimulus sequence
    initial begin
        for (int i = 0; i < MAP_WORDS; i++)
            chunk_words[i] = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(posedge aclk);

        // directed opening on an empty map
        queue_req(OP_ALLOC, 0);                   // lowest chunk of an empty map
        queue_req(OP_ALLOC, CHUNK_LIMIT - 1);     // index ignored on allocate
        queue_req(OP_MARK, 0);                    // mark of a used chunk
        queue_req(OP_MARK, CHUNK_LIMIT - 1);      // top chunk
        queue_req(OP_MARK, 2);
        queue_req(OP_ALLOC, 0);                   // skips the hole-free prefix
        for (int i = 4; i < 31; i += 3)
            queue_req(OP_MARK, i);
        queue_req(OP_MARK, 31);                   // last bit of word 0
        queue_req(OP_MARK, 32);                   // first bit of word 1
        queue_req(OP_ALLOC, 'h1ffff);
        queue_req(OP_ALLOC, 'h0aaaa);
        queue_req(OP_MARK, 'h15555);
        queue_req(OP_MARK, 'h0aaaa);
        queue_req(OP_MARK, 'h10000);
        queue_req(OP_ALLOC, 0);
        queue_req(OP_ALLOC, 0);
        wait_drained();

        // phase 0: no idling, with the long hold-off while words keep coming
        hold_go <= 1'b1;
        queue_random_reqs(100);
        wait_drained();

        // phase 1: sender idle half the time
        send_idle_pct  = 50;
        recv_stall_pct = 0;
        queue_random_reqs(100);
        wait_drained();

        // phase 2: receiver stalls half the time
        send_idle_pct  = 0;
        recv_stall_pct = 50;
        queue_random_reqs(100);
        wait_drained();

        // phase 3: both sides idle
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        queue_random_reqs(100);
        wait_drained();

        // directed tail at the ends of the index range
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_req(OP_ALLOC, 0);
        queue_req(OP_ALLOC, CHUNK_LIMIT - 1);
        queue_req(OP_MARK, 0);
        queue_req(OP_MARK, CHUNK_LIMIT - 1);
        queue_req(OP_MARK, $urandom_range(0, CHUNK_LIMIT - 1));
        queue_req(OP_ALLOC, $urandom_range(0, CHUNK_LIMIT - 1));
        wait_drained();
        repeat (50) @(posedge aclk);

        $display("run covered %0d request words and %0d checked results, map filled to %0d chunks",
                 taken_count, checked_count, used_count);
        $display("allocates on a full map: %0d, marks of used chunks: %0d",
                 full_count, remark_count);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog, far beyond a worst-case run with every scan at full length
    initial begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
